/* design/tlbs_pkg.sv */
// ----------------------------------------------------------------------------
// tlbs_pkg
// Shared types and constants for the table search block: request and
// response items, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
package tlbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_LINEAR = 2'd2,
    REQ_BINARY = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FOUND = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIN,
    S_BIN_ADDR,
    S_BIN_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    req_kind_t                  req_type;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   found_index;
    logic [CNT_W-1:0]   entry_count;
  } rsp_t;

endpackage

/* design/tlbs_ram.sv */
// ----------------------------------------------------------------------------
// tlbs_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tlbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/tlbs_ctrl.sv */
// ----------------------------------------------------------------------------
// tlbs_ctrl
// Request sequencer: owns the element table and count, runs appends and
// clears in one step, linear search as a pipelined scan, binary search as
// read-compare probe pairs.
// ----------------------------------------------------------------------------
module tlbs_ctrl #(
  parameter int TABLE_DEPTH = tlbs_pkg::TABLE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tlbs_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output tlbs_pkg::rsp_t res
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = tlbs_pkg::IDX_W;
  localparam int CNT_W = tlbs_pkg::CNT_W;
  localparam int VW    = tlbs_pkg::VALUE_W;

  tlbs_pkg::state_t  state, state_next;
  tlbs_pkg::status_t res_status;

  logic [CW-1:0]        count;
  logic signed [VW-1:0] key;
  logic [CW-1:0]        scan;
  logic                 pend;
  logic [AW-1:0]        pend_idx;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hi1;
  logic [AW-1:0]        mid;
  logic [AW-1:0]        res_index;

  logic                 mem_we;
  logic [AW-1:0]        mem_raddr;
  logic [VW-1:0]        mem_rdata;
  logic                 accept;
  logic                 full;
  logic                 lin_hit;
  logic                 lin_more;
  logic                 lin_end;
  logic                 bin_empty;
  logic [CW:0]          bin_sum;
  logic [AW-1:0]        mid_calc;
  logic                 probe_eq;
  logic                 probe_lt;

  tlbs_ram #(
    .WIDTH (VW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[AW-1:0]),
    .wdata (req.value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(TABLE_DEPTH));
  assign probe_eq  = (mem_rdata == key);
  assign probe_lt  = (key < $signed(mem_rdata));
  assign lin_hit   = pend && probe_eq;
  assign lin_more  = (scan < count);
  assign lin_end   = !pend && !lin_more;
  assign bin_empty = (lo >= hi1);
  assign bin_sum   = {1'b0, lo} + {1'b0, hi1} - (CW+1)'(1);
  assign mid_calc  = AW'(bin_sum >> 1);

  always_comb begin
    state_next = state;
    case (state)
      tlbs_pkg::S_IDLE: begin
        if (req_valid) begin
          case (req.req_type)
            tlbs_pkg::REQ_LINEAR: state_next = tlbs_pkg::S_LIN;
            tlbs_pkg::REQ_BINARY: state_next = tlbs_pkg::S_BIN_ADDR;
            default:              state_next = tlbs_pkg::S_DONE;
          endcase
        end
      end
      tlbs_pkg::S_LIN: begin
        if (lin_hit || lin_end) state_next = tlbs_pkg::S_DONE;
      end
      tlbs_pkg::S_BIN_ADDR: begin
        state_next = bin_empty ? tlbs_pkg::S_DONE : tlbs_pkg::S_BIN_CMP;
      end
      tlbs_pkg::S_BIN_CMP: begin
        state_next = probe_eq ? tlbs_pkg::S_DONE : tlbs_pkg::S_BIN_ADDR;
      end
      tlbs_pkg::S_DONE: begin
        if (res_ready) state_next = tlbs_pkg::S_IDLE;
      end
      default: state_next = tlbs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == tlbs_pkg::S_IDLE);
    res_valid = (state == tlbs_pkg::S_DONE);
    mem_we    = accept && (req.req_type == tlbs_pkg::REQ_APPEND) && !full;
    mem_raddr = (state == tlbs_pkg::S_BIN_ADDR) ? mid_calc : scan[AW-1:0];
    res.status      = res_status;
    res.found_index = IDX_W'(res_index);
    res.entry_count = CNT_W'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        tlbs_pkg::S_IDLE: begin
          if (accept) begin
            key        <= req.value;
            res_status <= tlbs_pkg::ST_DONE;
            res_index  <= '0;
            scan       <= '0;
            pend       <= 1'b0;
            lo         <= '0;
            hi1        <= count;
            case (req.req_type)
              tlbs_pkg::REQ_APPEND: begin
                if (full) begin
                  res_status <= tlbs_pkg::ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              tlbs_pkg::REQ_CLEAR: count <= '0;
              default: ;
            endcase
          end
        end
        tlbs_pkg::S_LIN: begin
          pend     <= lin_more;
          pend_idx <= scan[AW-1:0];
          if (lin_more) scan <= scan + CW'(1);
          if (lin_hit) begin
            res_status <= tlbs_pkg::ST_FOUND;
            res_index  <= pend_idx;
          end else if (lin_end) begin
            res_status <= tlbs_pkg::ST_MISS;
          end
        end
        tlbs_pkg::S_BIN_ADDR: begin
          mid <= mid_calc;
          if (bin_empty) res_status <= tlbs_pkg::ST_MISS;
        end
        tlbs_pkg::S_BIN_CMP: begin
          if (probe_eq) begin
            res_status <= tlbs_pkg::ST_FOUND;
            res_index  <= mid;
          end else if (probe_lt) begin
            hi1 <= CW'(mid);
          end else begin
            lo <= CW'(mid) + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_found_below_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == tlbs_pkg::ST_FOUND) |-> (CW'(res_index) < count))
    else $error("found index not below entry count");

  a_write_on_append: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (count == $past(count) + CW'(1)))
    else $error("table write without count advance");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != tlbs_pkg::S_IDLE))
    else $error("accepted item left no work");

  a_bin_window: assert property (@(posedge clk) disable iff (rst)
    (state == tlbs_pkg::S_BIN_CMP) |-> (hi1 <= count) && (CW'(mid) < hi1))
    else $error("binary probe outside search window");

endmodule

/* design/table_linear_binary_search.sv */
// ----------------------------------------------------------------------------
// table_linear_binary_search
// Table of signed 32-bit entries with append, clear, linear and binary search.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready with req (req_type, value); one
//   response per request leaves on rsp_valid/rsp_ready with rsp (status,
//   found_index, entry_count). One request is worked at a time.
//   Append and clear go from idle straight to the done state. A linear
//   search reads the table in index order up to the entry count, one
//   table read per cycle through the single RAM read port, and stops at
//   the first hit; a binary search runs probes of a RAM read, then a
//   compare, narrowing the window until a hit or an empty window.
//   The next request is taken in the cycle after the previous response
//   enters the output register; no new request is taken while one is
//   being worked.
//   The response sits in an output register; the next request is taken
//   while it waits. If the receiver stalls, a finished response holds in the
//   sequencer until the output register frees, and no further request is
//   taken until then.
//   Reset clears the entry count and the handshake state; table contents are
//   not cleared, and only entries below the count are used.
// ----------------------------------------------------------------------------
module table_linear_binary_search #(
  parameter int TABLE_DEPTH = tlbs_pkg::TABLE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tlbs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tlbs_pkg::rsp_t rsp
);

  logic           res_valid;
  logic           res_ready;
  tlbs_pkg::rsp_t res;

  tlbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule
